### design/abump_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abump_pkg
// Shared widths, codes and defaults of the arena bump allocator.
// ----------------------------------------------------------------------------
package abump_pkg;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 24;
  localparam int ALIGN_W = 17;
  localparam int CAP_W   = 25;

  localparam int HEADER_BYTES_DEF  = 64;
  localparam int POINTER_BYTES_DEF = 8;
  localparam int OFFSET_BITS_DEF   = 24;

  typedef logic [1:0] action_t;
  localparam action_t ACT_ALLOC    = 2'd0;
  localparam action_t ACT_RESIZE   = 2'd1;
  localparam action_t ACT_FREE     = 2'd2;
  localparam action_t ACT_FREE_ALL = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_OOM   = 2'd1;
  localparam status_t ST_NOSUP = 2'd2;

  localparam int CFG_INDEX_W = 1;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_ARENA_BASE     = 1'b0;
  localparam cfg_index_t CFG_ARENA_CAPACITY = 1'b1;

  typedef struct packed {
    action_t             action;
    logic                clear_request;
    logic [SIZE_W-1:0]   request_size;
    logic [ALIGN_W-1:0]  alignment;
    logic [ADDR_W-1:0]   old_address;
    logic [SIZE_W-1:0]   prev_size;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_address;
    logic [SIZE_W-1:0]   result_size;
    status_t             status;
    logic [ADDR_W-1:0]   zero_start;
    logic [SIZE_W-1:0]   zero_length;
  } rsp_t;

endpackage
`default_nettype wire

### design/abump_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abump_req_if
// Request channel: one allocator command per beat.
// ----------------------------------------------------------------------------
interface abump_req_if;
  import abump_pkg::*;

  logic                valid;
  logic                ready;
  action_t             action;
  logic                clear_request;
  logic [SIZE_W-1:0]   request_size;
  logic [ALIGN_W-1:0]  alignment;
  logic [ADDR_W-1:0]   old_address;
  logic [SIZE_W-1:0]   prev_size;

  modport source (
    output valid, action, clear_request, request_size, alignment, old_address, prev_size,
    input  ready
  );
  modport sink (
    input  valid, action, clear_request, request_size, alignment, old_address, prev_size,
    output ready
  );
endinterface
`default_nettype wire

### design/abump_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abump_rsp_if
// Result channel: one allocator answer per beat.
// ----------------------------------------------------------------------------
interface abump_rsp_if;
  import abump_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   result_address;
  logic [SIZE_W-1:0]   result_size;
  status_t             status;
  logic [ADDR_W-1:0]   zero_start;
  logic [SIZE_W-1:0]   zero_length;

  modport source (
    output valid, result_address, result_size, status, zero_start, zero_length,
    input  ready
  );
  modport sink (
    input  valid, result_address, result_size, status, zero_start, zero_length,
    output ready
  );
endinterface
`default_nettype wire

### design/abump_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abump_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface abump_cfg_if;
  import abump_pkg::*;

  logic                valid;
  logic                ready;
  cfg_index_t          index;
  logic [ADDR_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/arena_bump_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arena_bump_allocator
// Bump allocator over one arena: alloc, resize in place, free all.
//
//   channel  modport  beat carries
//   req      sink     action, clear_request, request_size, alignment,
//                     old_address, prev_size
//   rsp      source   result_address, result_size, status, zero_start,
//                     zero_length
//   cfg      sink     index (0 arena base address, 1 arena_capacity), data
//
// One request per cycle sustained while rsp is ready; input register, then
// result register, with the align-up add and capacity compares in between.
// Reset: used offset returns to HEADER_BYTES, base and capacity to zero.
// A stalled rsp holds its beat; the input register still takes one more beat,
// then req.ready drops until the result drains. cfg is always ready.
// ----------------------------------------------------------------------------
module arena_bump_allocator #(
  parameter int HEADER_BYTES  = abump_pkg::HEADER_BYTES_DEF,
  parameter int POINTER_BYTES = abump_pkg::POINTER_BYTES_DEF,
  parameter int OFFSET_BITS   = abump_pkg::OFFSET_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  abump_req_if.sink   req,
  abump_rsp_if.source rsp,
  abump_cfg_if.sink   cfg
);
  import abump_pkg::*;

  localparam int UW = OFFSET_BITS + 1;
  localparam logic [63:0] SIZE_MASK64 = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam logic [SIZE_W-1:0] SIZE_MASK = SIZE_MASK64[SIZE_W-1:0];
  localparam logic [UW-1:0] USED_RESET = UW'(HEADER_BYTES);

  logic [ADDR_W-1:0] base_addr;
  logic [CAP_W-1:0]  arena_capacity;
  logic [UW-1:0]     used_offset;
  logic [UW-1:0]     used_offset_next;

  logic in_valid;
  req_t in_q;
  logic out_valid;
  rsp_t out_q;
  rsp_t res;
  logic advance;

  // config writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr      <= '0;
      arena_capacity <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ARENA_BASE:     base_addr      <= cfg.data;
        CFG_ARENA_CAPACITY: arena_capacity <= cfg.data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q.action        <= req.action;
      in_q.clear_request <= req.clear_request;
      in_q.request_size  <= req.request_size;
      in_q.alignment     <= req.alignment;
      in_q.old_address   <= req.old_address;
      in_q.prev_size     <= req.prev_size;
    end
  end

  // alloc path
  logic [ALIGN_W-1:0] align_sel;
  logic [ALIGN_W-1:0] align_m1;
  logic [ADDR_W-1:0]  start_addr;
  logic [ADDR_W-1:0]  bumped;
  logic [ADDR_W-1:0]  aligned;
  logic [ADDR_W-1:0]  a_off;
  logic [ADDR_W:0]    a_end;
  logic               a_fits;

  assign align_sel  = (in_q.alignment > ALIGN_W'(POINTER_BYTES)) ? in_q.alignment
                                                                 : ALIGN_W'(POINTER_BYTES);
  assign align_m1   = align_sel - ALIGN_W'(1);
  assign start_addr = base_addr + ADDR_W'(used_offset) + ADDR_W'(POINTER_BYTES);
  assign bumped     = start_addr + ADDR_W'(align_m1);
  assign aligned    = bumped & ~ADDR_W'(align_m1);
  assign a_off      = aligned - base_addr;
  assign a_end      = {1'b0, a_off} + (ADDR_W+1)'(in_q.request_size);
  assign a_fits     = a_end <= (ADDR_W+1)'(arena_capacity);

  // resize path
  logic [ADDR_W-1:0] rel;
  logic              rel_bad;
  logic [ADDR_W:0]   r_end;
  logic [ADDR_W:0]   desired;
  logic              is_last;
  logic              d_fits;
  logic              grow;

  assign rel     = in_q.old_address - base_addr;
  assign rel_bad = (rel < ADDR_W'(HEADER_BYTES)) || (rel >= ADDR_W'(used_offset));
  assign r_end   = {1'b0, rel} + (ADDR_W+1)'(in_q.prev_size);
  assign desired = {1'b0, rel} + (ADDR_W+1)'(in_q.request_size);
  assign is_last = r_end == (ADDR_W+1)'(used_offset);
  assign d_fits  = desired <= (ADDR_W+1)'(arena_capacity);
  assign grow    = in_q.request_size > in_q.prev_size;

  always_comb begin
    res              = '0;
    res.status       = ST_OK;
    used_offset_next = used_offset;
    priority if (in_q.action == ACT_ALLOC ||
                 (in_q.action == ACT_RESIZE && in_q.old_address == '0)) begin
      if (in_q.request_size == '0) begin
        res.status = ST_OK;
      end else if (!a_fits) begin
        res.status = ST_OOM;
      end else begin
        used_offset_next   = a_end[UW-1:0];
        res.result_address = aligned;
        res.result_size    = in_q.request_size & SIZE_MASK;
        if (in_q.clear_request) begin
          res.zero_start  = aligned;
          res.zero_length = in_q.request_size & SIZE_MASK;
        end
      end
    end else if (in_q.action == ACT_RESIZE) begin
      if (rel_bad) begin
        res.status = ST_NOSUP;
      end else if (is_last) begin
        if (!d_fits) begin
          res.status = ST_OOM;
        end else begin
          used_offset_next   = desired[UW-1:0];
          res.result_address = in_q.old_address;
          res.result_size    = in_q.request_size & SIZE_MASK;
          if (in_q.clear_request && grow) begin
            res.zero_start  = in_q.old_address + ADDR_W'(in_q.prev_size);
            res.zero_length = (in_q.request_size - in_q.prev_size) & SIZE_MASK;
          end
        end
      end else if (!grow) begin
        res.result_address = in_q.old_address;
        res.result_size    = in_q.request_size & SIZE_MASK;
      end else begin
        res.status = ST_NOSUP;
      end
    end else if (in_q.action == ACT_FREE) begin
      res.status = ST_NOSUP;
    end else begin
      // rewind the arena
      used_offset_next = USED_RESET;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      used_offset <= USED_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        used_offset <= used_offset_next;
        out_valid   <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.result_address = out_q.result_address;
  assign rsp.result_size    = out_q.result_size;
  assign rsp.status         = out_q.status;
  assign rsp.zero_start     = out_q.zero_start;
  assign rsp.zero_length    = out_q.zero_length;

endmodule
`default_nettype wire
